FILE: rtl/rskg_pkg.sv
package rskg_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned COEF_W = 34;
  localparam int unsigned NUM_CAND = 10;
  localparam int unsigned CAND_IDX_W = 4;
  localparam logic [WORD_W-1:0] MIN_MODULUS = 32'd256;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_PRIME = 2'd1,
    STAT_SMALL_N   = 2'd2,
    STAT_SAME_PQ   = 2'd3
  } status_t;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quotient;
    logic [WORD_W-1:0] remainder;
  } div_rsp_t;

  // fixed list of public exponent candidates
  function automatic logic [WORD_W-1:0] cand_exp(input logic [CAND_IDX_W-1:0] idx);
    logic [WORD_W-1:0] v;
    case (idx)
      4'd0: v = 32'd17;
      4'd1: v = 32'd41;
      4'd2: v = 32'd97;
      4'd3: v = 32'd257;
      4'd4: v = 32'd769;
      4'd5: v = 32'd1153;
      4'd6: v = 32'd2113;
      4'd7: v = 32'd4128;
      4'd8: v = 32'd12289;
      4'd9: v = 32'd65537;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/rskg_div.sv
module rskg_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rskg_pkg::div_req_t req,
  output rskg_pkg::div_rsp_t rsp
);
  import rskg_pkg::*;

  logic [WORD_W-1:0] quo_r, quo_nxt;
  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic [WORD_W-1:0] dvs_r;
  logic [4:0]        cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [WORD_W:0]   rem_sh;
  logic [WORD_W+1:0] diff;

  // one restoring step per cycle
  always_comb begin
    rem_sh  = {rem_r, quo_r[WORD_W-1]};
    diff    = {1'b0, rem_sh} - {2'b00, dvs_r};
    if (!diff[WORD_W+1]) begin
      rem_nxt = diff[WORD_W-1:0];
      quo_nxt = {quo_r[WORD_W-2:0], 1'b1};
    end else begin
      rem_nxt = rem_sh[WORD_W-1:0];
      quo_nxt = {quo_r[WORD_W-2:0], 1'b0};
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !req.start) else $error("divider restarted while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without work");

endmodule

FILE: rtl/rsa_small_key_generator.sv
// work: trial division of both inputs takes up to 2 * 254 divisions, and the gcd
//   steps of the exponent search and the inverse search take more
// throughput: one request at a time, set by the shared 32-step divider
// reset: synchronous active-low rst_n returns the sequencer to idle and drops
//   the output valid
module rsa_small_key_generator #(
  parameter int unsigned PRIME_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [31:0]   in_tdata,   // prime_p [15:0], prime_q [31:16]
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [127:0]  out_tdata,  // modulus_n, totient, public_exp, private_exp
  output logic [1:0]    out_tuser   // status
);
  import rskg_pkg::*;

  typedef enum logic [15:0] {
    ST_IDLE    = 16'h0001,
    ST_PR_CHK  = 16'h0002,
    ST_PR_SQ   = 16'h0004,
    ST_PR_CMP  = 16'h0008,
    ST_PR_DIV  = 16'h0010,
    ST_MUL_N   = 16'h0020,
    ST_CHK_N   = 16'h0040,
    ST_MUL_PHI = 16'h0080,
    ST_E_TRY   = 16'h0100,
    ST_G_LOOP  = 16'h0200,
    ST_G_DIV   = 16'h0400,
    ST_X_LOOP  = 16'h0800,
    ST_X_DIV   = 16'h1000,
    ST_X_MUL   = 16'h2000,
    ST_X_UPD   = 16'h4000,
    ST_FIN     = 16'h8000
  } state_t;

  state_t state_r;

  logic [PRIME_BITS-1:0]  p_r, q_r;
  logic [WORD_W-1:0]      v_r, i_r;
  logic                   second_r;
  status_t                stat_r;
  logic [WORD_W-1:0]      n_r, phi_r, e_r, d_r;
  logic [CAND_IDX_W-1:0]  idx_r;
  logic                   fb_r;
  logic [WORD_W-1:0]      cand_r;
  logic [WORD_W-1:0]      ga_r, gb_r;
  logic [WORD_W-1:0]      r0_r, r1_r, quo_r;
  logic signed [COEF_W-1:0] t0_r, t1_r;
  logic signed [COEF_W-1:0] mul_r;
  logic signed [WORD_W:0]   mul_a, mul_b;
  logic signed [2*WORD_W+1:0] mul_full;
  logic signed [COEF_W-1:0] d_fix;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic              out_valid_r;
  logic [127:0]      out_data_r;
  logic [1:0]        out_user_r;

  rskg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_tready = (state_r == ST_IDLE);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_PR_SQ: begin
        mul_a = signed'({1'b0, i_r});
        mul_b = signed'({1'b0, i_r});
      end
      ST_MUL_N: begin
        mul_a = signed'({1'b0, WORD_W'(p_r)});
        mul_b = signed'({1'b0, WORD_W'(q_r)});
      end
      ST_MUL_PHI: begin
        mul_a = signed'({1'b0, WORD_W'(p_r) - 32'd1});
        mul_b = signed'({1'b0, WORD_W'(q_r) - 32'd1});
      end
      ST_X_MUL: begin
        mul_a = signed'({1'b0, quo_r});
        mul_b = (WORD_W+1)'(t1_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // divider request
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (state_r)
      ST_PR_CMP: begin
        div_req.start    = (mul_r[WORD_W-1:0] <= v_r);
        div_req.dividend = v_r;
        div_req.divisor  = i_r;
      end
      ST_G_LOOP: begin
        div_req.start    = (gb_r != '0);
        div_req.dividend = ga_r;
        div_req.divisor  = gb_r;
      end
      ST_X_LOOP: begin
        div_req.start    = (r1_r != '0);
        div_req.dividend = r0_r;
        div_req.divisor  = r1_r;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  assign d_fix = t0_r[COEF_W-1] ? (t0_r + signed'({2'b00, phi_r})) : t0_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            p_r      <= in_tdata[PRIME_BITS-1:0];
            q_r      <= in_tdata[16 +: PRIME_BITS];
            v_r      <= WORD_W'(in_tdata[PRIME_BITS-1:0]);
            second_r <= 1'b0;
            state_r  <= ST_PR_CHK;
          end
        end
        // trial division of the current value
        ST_PR_CHK: begin
          if (v_r < 32'd2) begin
            stat_r  <= STAT_NOT_PRIME;
            state_r <= ST_FIN;
          end else begin
            i_r     <= 32'd2;
            state_r <= ST_PR_SQ;
          end
        end
        ST_PR_SQ: begin
          mul_r   <= mul_full[COEF_W-1:0];
          state_r <= ST_PR_CMP;
        end
        ST_PR_CMP: begin
          if (mul_r[WORD_W-1:0] > v_r) begin
            if (!second_r) begin
              second_r <= 1'b1;
              v_r      <= WORD_W'(q_r);
              state_r  <= ST_PR_CHK;
            end else begin
              state_r <= ST_MUL_N;
            end
          end else begin
            state_r <= ST_PR_DIV;
          end
        end
        ST_PR_DIV: begin
          if (div_rsp.done) begin
            if (div_rsp.remainder == '0) begin
              stat_r  <= STAT_NOT_PRIME;
              state_r <= ST_FIN;
            end else begin
              i_r     <= i_r + 32'd1;
              state_r <= ST_PR_SQ;
            end
          end
        end
        // modulus and range checks
        ST_MUL_N: begin
          n_r     <= mul_full[WORD_W-1:0];
          state_r <= ST_CHK_N;
        end
        ST_CHK_N: begin
          if (n_r <= MIN_MODULUS) begin
            stat_r  <= STAT_SMALL_N;
            state_r <= ST_FIN;
          end else if (p_r == q_r) begin
            stat_r  <= STAT_SAME_PQ;
            state_r <= ST_FIN;
          end else begin
            stat_r  <= STAT_OK;
            state_r <= ST_MUL_PHI;
          end
        end
        ST_MUL_PHI: begin
          phi_r   <= mul_full[WORD_W-1:0];
          idx_r   <= '0;
          fb_r    <= 1'b0;
          cand_r  <= cand_exp('0);
          state_r <= ST_E_TRY;
        end
        // public exponent search
        ST_E_TRY: begin
          if (fb_r && (cand_r >= phi_r)) begin
            e_r     <= '0;
            d_r     <= '0;
            state_r <= ST_FIN;
          end else begin
            ga_r    <= cand_r;
            gb_r    <= phi_r;
            state_r <= ST_G_LOOP;
          end
        end
        ST_G_LOOP: begin
          if (gb_r != '0) begin
            state_r <= ST_G_DIV;
          end else if (ga_r == 32'd1) begin
            e_r     <= cand_r;
            r0_r    <= phi_r;
            r1_r    <= cand_r;
            t0_r    <= '0;
            t1_r    <= COEF_W'(1);
            state_r <= ST_X_LOOP;
          end else begin
            if (fb_r) begin
              cand_r <= cand_r + 32'd1;
            end else if (idx_r == CAND_IDX_W'(NUM_CAND - 1)) begin
              fb_r   <= 1'b1;
              cand_r <= 32'd2;
            end else begin
              idx_r  <= idx_r + 1'b1;
              cand_r <= cand_exp(idx_r + 1'b1);
            end
            state_r <= ST_E_TRY;
          end
        end
        ST_G_DIV: begin
          if (div_rsp.done) begin
            ga_r    <= gb_r;
            gb_r    <= div_rsp.remainder;
            state_r <= ST_G_LOOP;
          end
        end
        // inverse of e modulo phi by extended euclid
        ST_X_LOOP: begin
          if (r1_r == '0) begin
            d_r     <= d_fix[WORD_W-1:0];
            state_r <= ST_FIN;
          end else begin
            state_r <= ST_X_DIV;
          end
        end
        ST_X_DIV: begin
          if (div_rsp.done) begin
            quo_r   <= div_rsp.quotient;
            r0_r    <= r1_r;
            r1_r    <= div_rsp.remainder;
            state_r <= ST_X_MUL;
          end
        end
        ST_X_MUL: begin
          mul_r   <= mul_full[COEF_W-1:0];
          state_r <= ST_X_UPD;
        end
        ST_X_UPD: begin
          t0_r    <= t1_r;
          t1_r    <= t0_r - mul_r;
          state_r <= ST_X_LOOP;
        end
        // hand the result to the output register
        ST_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_user_r  <= stat_r;
            if (stat_r == STAT_OK) begin
              out_data_r <= {d_r, e_r, phi_r, n_r};
            end else begin
              out_data_r <= '0;
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r != ST_IDLE))
    else $error("request accepted but sequencer stayed idle");
  a_inverse_gcd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_X_LOOP && r1_r == '0) |-> (r0_r == 32'd1))
    else $error("public exponent not coprime with totient");
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != STAT_OK) |-> (out_tdata == '0))
    else $error("error result carries nonzero data");
  a_fin_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_valid_r && !out_tready) |=> (state_r == ST_FIN))
    else $error("pending result overwritten");

endmodule

FILE: tb/rsa_small_key_generator_tb.sv
`timescale 1ns / 1ps

module rsa_small_key_generator_tb;
  import rskg_pkg::*;

  localparam int unsigned P_BITS = 16;
  localparam longint unsigned CYCLE_LIMIT = 64'd40_000_000;

  typedef struct packed {
    status_t     status;
    logic [31:0] modulus_n;
    logic [31:0] totient;
    logic [31:0] public_exp;
    logic [31:0] private_exp;
  } key_set_t;

  logic [31:0] cand_list [NUM_CAND] = '{32'd17, 32'd41, 32'd97, 32'd257, 32'd769,
                                        32'd1153, 32'd2113, 32'd4128, 32'd12289,
                                        32'd65537};

  // key set math
  function automatic logic [31:0] gcd_u32(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic bit prime_by_trial(input logic [31:0] v);
    logic [31:0] i;
    if (v < 2) return 0;
    for (i = 2; i * i <= v; i++) begin
      if (v % i == 0) return 0;
    end
    return 1;
  endfunction

  function automatic logic [31:0] choose_pub_exp(input logic [31:0] phi);
    logic [31:0] i;
    for (int k = 0; k < NUM_CAND; k++) begin
      if (gcd_u32(cand_list[k], phi) == 1) return cand_list[k];
    end
    for (i = 2; i < phi; i++) begin
      if (gcd_u32(i, phi) == 1) return i;
    end
    return 0;
  endfunction

  function automatic logic [31:0] choose_priv_exp(input logic [31:0] phi,
                                                  input logic [31:0] e);
    logic [63:0] k;
    logic [63:0] t;
    if (e == 0) return 0;
    for (k = 1; k <= {32'd0, e}; k++) begin
      t = k * {32'd0, phi} + 64'd1;
      if (t % {32'd0, e} == 0) return 32'(t / {32'd0, e});
    end
    return 0;
  endfunction

  function automatic key_set_t make_key_set(input logic [15:0] pin, input logic [15:0] qin);
    key_set_t r;
    logic [31:0] p;
    logic [31:0] q;
    p = {16'd0, pin} & ((32'd1 << P_BITS) - 1);
    q = {16'd0, qin} & ((32'd1 << P_BITS) - 1);
    r = '0;
    if (!prime_by_trial(p) || !prime_by_trial(q)) r.status = STAT_NOT_PRIME;
    else if (p * q <= MIN_MODULUS) r.status = STAT_SMALL_N;
    else if (p == q) r.status = STAT_SAME_PQ;
    else begin
      r.status = STAT_OK;
      r.modulus_n = p * q;
      r.totient = (p - 1) * (q - 1);
      r.public_exp = choose_pub_exp(r.totient);
      r.private_exp = choose_priv_exp(r.totient, r.public_exp);
    end
    return r;
  endfunction

  // expected key sets, oldest first
  class key_scoreboard;
    key_set_t pending_keys[$];
    int errors = 0;

    function void note_request(input logic [15:0] p, input logic [15:0] q);
      pending_keys = {pending_keys, make_key_set(p, q)};
    endfunction

    function void check_key_set(input logic [1:0] user, input logic [127:0] data);
      key_set_t exp_k;
      if (pending_keys.size() == 0) begin
        $display("%0t: unexpected result status=%0d data=%h", $realtime, user, data);
        errors++;
        return;
      end
      exp_k = pending_keys.pop_front();
      if (user != exp_k.status) begin
        $display("%0t: status expected %0d actual %0d", $realtime, exp_k.status, user);
        errors++;
      end
      if (data[31:0] != exp_k.modulus_n) begin
        $display("%0t: modulus_n expected %0d actual %0d", $realtime,
                 exp_k.modulus_n, data[31:0]);
        errors++;
      end
      if (data[63:32] != exp_k.totient) begin
        $display("%0t: totient expected %0d actual %0d", $realtime,
                 exp_k.totient, data[63:32]);
        errors++;
      end
      if (data[95:64] != exp_k.public_exp) begin
        $display("%0t: public_exp expected %0d actual %0d", $realtime,
                 exp_k.public_exp, data[95:64]);
        errors++;
      end
      if (data[127:96] != exp_k.private_exp) begin
        $display("%0t: private_exp expected %0d actual %0d", $realtime,
                 exp_k.private_exp, data[127:96]);
        errors++;
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [31:0]  in_tdata = '0;   // prime_p [15:0], prime_q [31:16]
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [127:0] out_tdata;       // modulus_n, totient, public_exp, private_exp
  logic [1:0]   out_tuser;       // status

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  longint unsigned cycle_count = 0;
  key_scoreboard sb = new();
  logic [15:0] prime_pool[$];

  rsa_small_key_generator #(.PRIME_BITS(P_BITS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always #4 clk = ~clk;

  // receiver with random stalls
  always @(negedge clk) begin
    out_tready = rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // result check and watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (rst_n && out_tvalid && out_tready) sb.check_key_set(out_tuser, out_tdata);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("rsa_small_key_generator test failed");
      $finish;
    end
  end

  // one request, with random idle cycles ahead of it
  task automatic send_request(input logic [15:0] p, input logic [15:0] q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 0;
      @(negedge clk);
    end
    in_tvalid = 1;
    in_tdata = {q, p};
    do @(posedge clk); while (!in_tready);
    sb.note_request(p, q);
    @(negedge clk);
    in_tvalid = 0;
  endtask

  task automatic wait_drained();
    while (sb.pending_keys.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_prime();
    return prime_pool[$urandom_range(prime_pool.size() - 1)];
  endfunction

  function automatic logic [15:0] pick_composite();
    logic [15:0] v;
    do v = 16'($urandom_range(4, 2000)); while (prime_by_trial({16'd0, v}));
    return v;
  endfunction

  task automatic random_phase(input int count);
    logic [15:0] p;
    logic [15:0] q;
    int pick;
    repeat (count) begin
      pick = $urandom_range(99);
      p = pick_prime();
      q = pick_prime();
      if (pick < 8) q = p;
      else if (pick < 18) begin
        p = 16'($urandom);
        q = 16'($urandom);
      end else if (pick < 28) begin
        if ($urandom_range(1)) p = pick_composite(); else q = pick_composite();
      end else if (pick < 36) begin
        p = 16'($urandom_range(0, 19));
        q = 16'($urandom_range(0, 19));
      end
      send_request(p, q);
    end
  endtask

  initial begin
    logic [15:0] v;
    // pool of small primes plus a few random large ones
    for (int i = 2; i < 600; i++) if (prime_by_trial(i)) prime_pool = {prime_pool, 16'(i)};
    repeat (6) begin
      do v = 16'($urandom_range(30000, 65535)); while (!prime_by_trial({16'd0, v}));
      prime_pool = {prime_pool, v};
    end

    repeat (5) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // directed: extremes, each status, exponent fallthrough
    send_request(16'd0, 16'd0);
    send_request(16'd1, 16'd17);
    send_request(16'hFFFF, 16'hFFFF);
    send_request(16'd65521, 16'd65519);
    send_request(16'd2, 16'd3);
    send_request(16'd13, 16'd19);
    send_request(16'd2, 16'd131);
    send_request(16'd17, 16'd17);
    send_request(16'd65521, 16'd65521);
    send_request(16'd61, 16'd53);
    send_request(16'd103, 16'd83);
    send_request(16'd83, 16'd103);
    send_request(16'd103, 16'd197);
    send_request(16'd15, 16'd23);
    send_request(16'd23, 16'd65535);
    send_request(16'd32771, 16'd3);

    // random phases with varying backpressure
    send_idle_pct = 0;  recv_stall_pct = 0;  random_phase(25);
    wait_drained();
    send_idle_pct = 68; recv_stall_pct = 0;  random_phase(25);
    send_idle_pct = 0;  recv_stall_pct = 68; random_phase(25);
    send_idle_pct = 14; recv_stall_pct = 14; random_phase(25);

    wait_drained();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending_keys.size() == 0) begin
      $display("rsa_small_key_generator test passed");
    end else begin
      $display("rsa_small_key_generator test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/rskg_pkg.sv
rtl/rskg_div.sv
rtl/rsa_small_key_generator.sv
tb/rsa_small_key_generator_tb.sv
